@@ design/jtl_pkg.sv @@
// ----------------------------------------------------------------------------
// jtl_pkg - shared definitions for the JSON token lexer
// Token codes, lexer modes, character constants and the result bundle
// that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package jtl_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [3:0] TT_STRING = 4'd0;
    localparam logic [3:0] TT_LBRACE = 4'd1;
    localparam logic [3:0] TT_RBRACE = 4'd2;
    localparam logic [3:0] TT_LBRACK = 4'd3;
    localparam logic [3:0] TT_RBRACK = 4'd4;
    localparam logic [3:0] TT_COLON  = 4'd5;
    localparam logic [3:0] TT_COMMA  = 4'd6;
    localparam logic [3:0] TT_NUMBER = 4'd7;
    localparam logic [3:0] TT_ERROR  = 4'd8;
    localparam logic [3:0] TT_ACCEPT = 4'd9;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_NUM  = 2'd2;
    localparam logic [1:0] MODE_ERR  = 2'd3;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOT  = 1'b1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [3:0] token_type;
        logic [7:0] content;
        logic       is_content;
        logic       last;
    } t_result;

    // Up to two results caused by one input item; first is always valid.
    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_bundle;

endpackage

@@ design/jtl_front.sv @@
// ----------------------------------------------------------------------------
// jtl_front - lexer front end
// Holds the lexer mode and dot flag, classifies each accepted character or
// end-of-text marker and writes the results it causes into the queue as one bundle.
// ----------------------------------------------------------------------------
module jtl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_ch,
    output logic              o_wr_en,
    output jtl_pkg::t_bundle  o_wr_data
);
    import jtl_pkg::*;

    logic [1:0] r_mode, n_mode;
    logic       r_dot, n_dot;

    typedef struct packed {
        logic       emit;
        t_result    res;
        logic [1:0] mode;
    } t_idle_out;

    function automatic t_result mk(input logic [3:0] tt, input logic [7:0] c,
                                   input logic isc);
        t_result r;
        r.token_type = tt;
        r.content    = c;
        r.is_content = isc;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_idle_out lex_idle(input logic [7:0] c);
        t_idle_out o;
        o.emit = 1'b1;
        o.mode = MODE_IDLE;
        o.res  = mk(TT_ERROR, 8'd0, 1'b0);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            o.emit = 1'b0;
        end else if (c == CH_QUOTE) begin
            o.emit = 1'b0;
            o.mode = MODE_STR;
        end else if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) begin
            o.mode = MODE_NUM;
            o.res  = mk(TT_NUMBER, c, 1'b1);
        end else begin
            unique case (c)
                CH_LBRACE: o.res = mk(TT_LBRACE, 8'd0, 1'b0);
                CH_RBRACE: o.res = mk(TT_RBRACE, 8'd0, 1'b0);
                CH_LBRACK: o.res = mk(TT_LBRACK, 8'd0, 1'b0);
                CH_RBRACK: o.res = mk(TT_RBRACK, 8'd0, 1'b0);
                CH_COLON:  o.res = mk(TT_COLON, 8'd0, 1'b0);
                CH_COMMA:  o.res = mk(TT_COMMA, 8'd0, 1'b0);
                default:   o.mode = MODE_ERR;
            endcase
        end
        return o;
    endfunction

    t_idle_out idle_res;
    t_result   res0, res1;
    logic [1:0] count;

    always_comb begin
        idle_res = lex_idle(i_ch);
        res0     = mk(TT_ERROR, 8'd0, 1'b0);
        res1     = mk(TT_ERROR, 8'd0, 1'b0);
        count    = 2'd0;
        n_mode   = r_mode;
        n_dot    = r_dot;
        if (i_kind == KIND_EOT) begin
            res0   = mk((r_mode == MODE_IDLE) ? TT_ACCEPT : TT_ERROR, 8'd0, 1'b0);
            count  = 2'd1;
            n_mode = MODE_IDLE;
            n_dot  = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    res0   = idle_res.res;
                    count  = {1'b0, idle_res.emit};
                    n_mode = idle_res.mode;
                    n_dot  = 1'b0;
                end
                MODE_STR: begin
                    count = 2'd1;
                    if (i_ch == CH_QUOTE) begin
                        res0   = mk(TT_STRING, 8'd0, 1'b0);
                        n_mode = MODE_IDLE;
                    end else begin
                        res0 = mk(TT_STRING, i_ch, 1'b1);
                    end
                end
                MODE_NUM: begin
                    count = 2'd1;
                    if (i_ch == CH_DOT) begin
                        if (r_dot) begin
                            res0   = mk(TT_ERROR, 8'd0, 1'b0);
                            n_mode = MODE_ERR;
                        end else begin
                            res0  = mk(TT_NUMBER, i_ch, 1'b1);
                            n_dot = 1'b1;
                        end
                    end else if (is_digit(i_ch)) begin
                        res0 = mk(TT_NUMBER, i_ch, 1'b1);
                    end else begin
                        // The terminating character is lexed again as if idle.
                        res0   = mk(TT_NUMBER, 8'd0, 1'b0);
                        res1   = idle_res.res;
                        count  = idle_res.emit ? 2'd2 : 2'd1;
                        n_mode = idle_res.mode;
                        n_dot  = 1'b0;
                    end
                end
                default: begin
                    count = 2'd0;
                end
            endcase
        end
        res0.last = (count == 2'd1);
        res1.last = 1'b1;
    end

    assign o_wr_en          = i_accept && (count != 2'd0);
    assign o_wr_data.first  = res0;
    assign o_wr_data.second = res1;
    assign o_wr_data.two    = (count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_dot  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
        end
    end

endmodule

@@ design/jtl_queue.sv @@
// ----------------------------------------------------------------------------
// jtl_queue - result bundle queue
// A small first-in first-out store that decouples the front end from the
// back end, so that each side may stall on its own.
// ----------------------------------------------------------------------------
module jtl_queue #(
    parameter int unsigned Depth = jtl_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  jtl_pkg::t_bundle  i_wr_data,
    output logic              o_full,
    input  logic              i_rd_en,
    output jtl_pkg::t_bundle  o_rd_data,
    output logic              o_empty
);
    import jtl_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_bundle         r_store [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_wr, do_rd;

    assign o_full    = (r_count == FullCnt);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_store[r_rd_ptr];
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_store[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LastIdx) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LastIdx) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/jtl_back.sv @@
// ----------------------------------------------------------------------------
// jtl_back - lexer back end
// Takes bundles from the queue and hands their results out one per
// transfer from an output register.
// ----------------------------------------------------------------------------
module jtl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  jtl_pkg::t_bundle  i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output jtl_pkg::t_result  o_result
);
    import jtl_pkg::*;

    t_bundle r_bundle;
    logic    r_valid;
    logic    r_second;
    logic    take;

    // A new bundle is loaded when the register is empty or its final result leaves.
    assign take    = !r_valid || (i_pop && (r_second || !r_bundle.two));
    assign o_q_pop = take && !i_q_empty;
    assign o_empty = !r_valid;
    assign o_result = r_second ? r_bundle.second : r_bundle.first;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bundle <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (take) begin
            r_valid  <= !i_q_empty;
            r_second <= 1'b0;
        end else if (i_pop) begin
            r_second <= 1'b1;
        end
    end

endmodule

@@ design/json_token_lexer.sv @@
// ----------------------------------------------------------------------------
// json_token_lexer - streaming lexer for a reduced JSON text
// One character or end-of-text marker per input transfer; string and number
// content, token ends, punctuation and a final status come out as results.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake          Payload
//  -------  -----------------  ---------------------------------------------
//  input    push / full        i_kind, i_ch
//  result   empty / pop        o_token_type, o_content, o_is_content, o_last
//
// The front end classifies each input transfer at once.
// Items causing one result sustain one per cycle while results are popped
// and full stays low; a number ended by a sign, punctuation or unknown
// character causes two and occupies the output for two transfers.
// The bundle queue of QueueDepth entries lets input continue while results
// wait; full rises only when the queue has no room left.
// Reset (synchronous, active low) returns the mode to idle and empties the
// queue and output register.
// ----------------------------------------------------------------------------
module json_token_lexer #(
    parameter int unsigned QueueDepth = jtl_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_kind,
    input  logic [7:0] i_ch,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_token_type,
    output logic [7:0] o_content,
    output logic       o_is_content,
    output logic       o_last
);
    import jtl_pkg::*;

    logic    accept;
    logic    q_wr_en, q_full, q_rd_en, q_empty;
    t_bundle q_wr_data, q_rd_data;
    t_result result;

    // The front end may only take a character when its bundle is sure to fit.
    assign full   = q_full;
    assign accept = push && !q_full;

    jtl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_kind    (i_kind),
        .i_ch      (i_ch),
        .o_wr_en   (q_wr_en),
        .o_wr_data (q_wr_data)
    );

    jtl_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr_en),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd_en   (q_rd_en),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // The back end serialises each bundle, one result per output transfer.
    jtl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_q_pop   (q_rd_en),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_token_type = result.token_type;
    assign o_content    = result.content;
    assign o_is_content = result.is_content;
    assign o_last       = result.last;

endmodule
